// File: hdl/complex_number_alu_top_assert.svh
// Assertion macros for the complex arithmetic unit.
// Needs clk and rst in the scope of the including module.
`ifndef COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define CNA_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle
`define CNA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cna_pkg.sv
// Shared types and defaults for the complex arithmetic unit.
// No dependencies.
package cna_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  // Control that travels with each pipeline slot
  typedef struct packed {
    logic valid;
    logic is_div;
  } stage_ctl_t;

endpackage

// File: hdl/cna_div_stage.sv
// One restoring-division step for the real and imaginary quotients.
// Depends on cna_pkg.
module cna_div_stage import cna_pkg::*; #(
  parameter int NW = 114,
  parameter int PW = 64,
  parameter int QW = 33,
  parameter int SH = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  stage_ctl_t      ctl_in,
  input  logic [NW-1:0]   rem_r_in,
  input  logic [NW-1:0]   rem_i_in,
  input  logic [PW-1:0]   den_in,
  input  logic [QW-1:0]   q_r_in,
  input  logic [QW-1:0]   q_i_in,
  output stage_ctl_t      ctl_out,
  output logic [NW-1:0]   rem_r_out,
  output logic [NW-1:0]   rem_i_out,
  output logic [PW-1:0]   den_out,
  output logic [QW-1:0]   q_r_out,
  output logic [QW-1:0]   q_i_out
);

  logic [NW-1:0] dsh;
  logic          ge_r;
  logic          ge_i;

  // Compare the partial remainders against the shifted divisor
  always_comb begin
    dsh  = NW'(den_in) << SH;
    ge_r = ctl_in.is_div && (rem_r_in >= dsh);
    ge_i = ctl_in.is_div && (rem_i_in >= dsh);
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  // Subtract and record the quotient bit
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r_out <= ge_r ? rem_r_in - dsh : rem_r_in;
      rem_i_out <= ge_i ? rem_i_in - dsh : rem_i_in;
      den_out   <= den_in;
      q_r_out   <= q_r_in | (QW'(ge_r) << SH);
      q_i_out   <= q_i_in | (QW'(ge_i) << SH);
    end
  end

endmodule

// File: hdl/complex_number_alu_top.sv
// Complex arithmetic unit: add, subtract, multiply and divide of signed fixed-point
// complex operands, with saturation and a divide-by-zero flag. Fully pipelined:
// one transfer is accepted every cycle while the output is not stalled, and each
// result passes through product, sum and setup stages, the division chain with one
// quotient bit per stage (DATA_WIDTH + 1 steps) and an output stage. A stall
// on the output holds the whole pipeline. Depends on cna_pkg and cna_div_stage.
`include "complex_number_alu_top_assert.svh"

module complex_number_alu_top import cna_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result_real,
  output logic signed [DATA_WIDTH-1:0] result_imag,
  output logic                         divide_by_zero,
  output logic                         overflow
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int XW = PW + 1;
  localparam int NW = 3 * W + F + 2;
  localparam int QW = W + 1;
  localparam int ND = W + 1;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

  logic adv;

  // Hold everything while the output waits
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: products and linear sums ----------------
  logic                s1_vld;
  opcode_t             s1_op;
  logic                s1_dz;
  logic signed [PW-1:0] s1_p0, s1_p1, s1_p2, s1_p3, s1_p4, s1_p5;
  logic signed [W:0]   s1_sr, s1_si;
  logic signed [W:0]   ar_x, ai_x, br_x, bi_x;

  always_comb begin
    ar_x = {a_real[W-1], a_real};
    ai_x = {a_imag[W-1], a_imag};
    br_x = {b_real[W-1], b_real};
    bi_x = {b_imag[W-1], b_imag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= opcode_t'(opcode);
      s1_dz <= (opcode_t'(opcode) == OP_DIV) && (b_real == '0) && (b_imag == '0);
      s1_p0 <= a_real * b_real;
      s1_p1 <= a_imag * b_imag;
      s1_p2 <= a_real * b_imag;
      s1_p3 <= a_imag * b_real;
      s1_p4 <= b_real * b_real;
      s1_p5 <= b_imag * b_imag;
      s1_sr <= (opcode_t'(opcode) == OP_SUB) ? ar_x - br_x : ar_x + br_x;
      s1_si <= (opcode_t'(opcode) == OP_SUB) ? ai_x - bi_x : ai_x + bi_x;
    end
  end

  // ---------------- stage 2: product sums ----------------
  logic                s2_vld;
  opcode_t             s2_op;
  logic                s2_dz;
  logic signed [W:0]   s2_sr, s2_si;
  logic signed [XW-1:0] s2_xr, s2_xi;
  logic [PW-1:0]       s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op  <= s1_op;
      s2_dz  <= s1_dz;
      s2_sr  <= s1_sr;
      s2_si  <= s1_si;
      if (s1_op == OP_MUL) begin
        s2_xr <= XW'(s1_p0) - XW'(s1_p1);
        s2_xi <= XW'(s1_p2) + XW'(s1_p3);
      end else begin
        s2_xr <= XW'(s1_p0) + XW'(s1_p1);
        s2_xi <= XW'(s1_p3) - XW'(s1_p2);
      end
      s2_den <= $unsigned(s1_p4) + $unsigned(s1_p5);
    end
  end

  // ---------------- stage 3: non-divide results, divide setup ----------------
  stage_ctl_t    ctl   [0:ND];
  logic [NW-1:0] rem_r [0:ND];
  logic [NW-1:0] rem_i [0:ND];
  logic [PW-1:0] den   [0:ND];
  logic [QW-1:0] q_r   [0:ND];
  logic [QW-1:0] q_i   [0:ND];
  logic signed [W-1:0] d_rr [0:ND];
  logic signed [W-1:0] d_ri [0:ND];
  logic          d_ovf [0:ND];
  logic          d_dz  [0:ND];
  logic          d_negr [0:ND];
  logic          d_negi [0:ND];
  logic          d_bigr [0:ND];
  logic          d_bigi [0:ND];

  logic signed [XW-1:0] sh_r, sh_i;
  logic [XW-1:0]        mag_r, mag_i;
  logic [NW-1:0]        num_r, num_i, den_top;
  logic                 o_r, o_i;
  logic signed [W-1:0]  v_r, v_i;

  always_comb begin
    sh_r    = s2_xr >>> F;
    sh_i    = s2_xi >>> F;
    mag_r   = s2_xr[XW-1] ? XW'(-s2_xr) : XW'(s2_xr);
    mag_i   = s2_xi[XW-1] ? XW'(-s2_xi) : XW'(s2_xi);
    num_r   = NW'(mag_r) << F;
    num_i   = NW'(mag_i) << F;
    den_top = NW'(s2_den) << QW;
    o_r = 1'b0;
    o_i = 1'b0;
    v_r = '0;
    v_i = '0;
    case (s2_op)
      OP_ADD, OP_SUB: begin
        o_r = s2_sr[W] != s2_sr[W-1];
        o_i = s2_si[W] != s2_si[W-1];
        v_r = o_r ? (s2_sr[W] ? MINV : MAXV) : s2_sr[W-1:0];
        v_i = o_i ? (s2_si[W] ? MINV : MAXV) : s2_si[W-1:0];
      end
      OP_MUL: begin
        o_r = sh_r[XW-1:W-1] != {(XW-W+1){sh_r[XW-1]}};
        o_i = sh_i[XW-1:W-1] != {(XW-W+1){sh_i[XW-1]}};
        v_r = o_r ? (sh_r[XW-1] ? MINV : MAXV) : sh_r[W-1:0];
        v_i = o_i ? (sh_i[XW-1] ? MINV : MAXV) : sh_i[W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (adv) begin
      ctl[0].valid  <= s2_vld;
      ctl[0].is_div <= (s2_op == OP_DIV) && !s2_dz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= num_r;
      rem_i[0]  <= num_i;
      den[0]    <= s2_den;
      q_r[0]    <= '0;
      q_i[0]    <= '0;
      d_rr[0]   <= v_r;
      d_ri[0]   <= v_i;
      d_ovf[0]  <= o_r || o_i;
      d_dz[0]   <= s2_dz;
      d_negr[0] <= s2_xr[XW-1];
      d_negi[0] <= s2_xi[XW-1];
      d_bigr[0] <= num_r >= den_top;
      d_bigi[0] <= num_i >= den_top;
    end
  end

  // ---------------- division chain, one quotient bit per stage ----------------
  for (genvar k = 0; k < ND; k++) begin : g_div
    cna_div_stage #(
      .NW(NW), .PW(PW), .QW(QW), .SH(W - k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl_in   (ctl[k]),
      .rem_r_in (rem_r[k]),
      .rem_i_in (rem_i[k]),
      .den_in   (den[k]),
      .q_r_in   (q_r[k]),
      .q_i_in   (q_i[k]),
      .ctl_out  (ctl[k+1]),
      .rem_r_out(rem_r[k+1]),
      .rem_i_out(rem_i[k+1]),
      .den_out  (den[k+1]),
      .q_r_out  (q_r[k+1]),
      .q_i_out  (q_i[k+1])
    );

    // Carry the side data alongside
    always_ff @(posedge clk) begin
      if (adv) begin
        d_rr[k+1]   <= d_rr[k];
        d_ri[k+1]   <= d_ri[k];
        d_ovf[k+1]  <= d_ovf[k];
        d_dz[k+1]   <= d_dz[k];
        d_negr[k+1] <= d_negr[k];
        d_negi[k+1] <= d_negi[k];
        d_bigr[k+1] <= d_bigr[k];
        d_bigi[k+1] <= d_bigi[k];
      end
    end
  end

  // ---------------- output stage: sign and saturate quotients ----------------
  logic                sat_r, sat_i;
  logic [QW-1:0]       sq_r, sq_i;
  logic signed [W-1:0] f_r, f_i;
  logic                f_ovf;

  always_comb begin
    sat_r = d_bigr[ND] || (q_r[ND] > (d_negr[ND] ? HALF : HALF - QW'(1)));
    sat_i = d_bigi[ND] || (q_i[ND] > (d_negi[ND] ? HALF : HALF - QW'(1)));
    sq_r  = d_negr[ND] ? QW'(-q_r[ND]) : q_r[ND];
    sq_i  = d_negi[ND] ? QW'(-q_i[ND]) : q_i[ND];
    if (ctl[ND].is_div) begin
      f_r   = sat_r ? (d_negr[ND] ? MINV : MAXV) : sq_r[W-1:0];
      f_i   = sat_i ? (d_negi[ND] ? MINV : MAXV) : sq_i[W-1:0];
      f_ovf = sat_r || sat_i;
    end else begin
      f_r   = d_rr[ND];
      f_i   = d_ri[ND];
      f_ovf = d_ovf[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl[ND].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_real    <= f_r;
      result_imag    <= f_i;
      divide_by_zero <= d_dz[ND];
      overflow       <= f_ovf;
    end
  end

  // ---------------- checks ----------------
  `CNA_CHK_NOW(a_dz_zero, out_valid && divide_by_zero,
    result_real == '0 && result_imag == '0 && !overflow, "zero divisor result not clean")
  `CNA_CHK_NOW(a_ovf_limit, out_valid && overflow,
    result_real == MAXV || result_real == MINV || result_imag == MAXV ||
    result_imag == MINV, "overflow without saturated part")
  `CNA_CHK_NEXT(a_stall_hold, !adv, $stable(s1_vld) && $stable(ctl[0]),
    "pipeline moved during stall")

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the complex arithmetic unit: directed table plus random operands,
// each result checked against a stored expectation or a wide-integer predictor.
// Depends on cna_pkg and complex_number_alu_top.
`timescale 1ns / 100ps

module tb_top;
  import cna_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LIMIT = 400000;
  localparam int N_RAND = 1000;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [191:0] wide_t;

  typedef struct {
    word_t re;
    word_t im;
    logic  dz;
    logic  ovf;
  } cplx_res_t;

  typedef struct {
    opcode_t   op;
    word_t     ar, ai, br, bi;
    bit        typed;
    cplx_res_t res;
  } vec_t;

  localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = OP_ADD;
  word_t a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  word_t result_real, result_imag;
  logic divide_by_zero, overflow;

  cplx_res_t cplx_expected_q[$];
  bit        cur_typed = 1'b0;
  cplx_res_t cur_res;
  int        n_in_xfer = 0;
  int        cycles = 0;
  bit        failed = 1'b0;
  bit        no_idle = 1'b0;

  complex_number_alu_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .a_real(a_real), .a_imag(a_imag),
    .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_real(result_real), .result_imag(result_imag),
    .divide_by_zero(divide_by_zero), .overflow(overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clamp one wide part to the word range, flag saturation
  function automatic word_t clamp_part(input wide_t v, inout logic ovf);
    wide_t hi, lo;
    hi = WMAX;
    lo = WMIN;
    if (v > hi) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return WMIN;
    end
    return word_t'(v);
  endfunction

  function automatic cplx_res_t cplx_compute(input opcode_t op, input word_t ar, input word_t ai,
                                             input word_t br, input word_t bi);
    wide_t xr, xi, yr, yi, re, im, den;
    cplx_res_t r;
    xr = ar; xi = ai; yr = br; yi = bi;
    r.dz = 1'b0;
    r.ovf = 1'b0;
    case (op)
      OP_ADD: begin
        re = xr + yr;
        im = xi + yi;
      end
      OP_SUB: begin
        re = xr - yr;
        im = xi - yi;
      end
      OP_MUL: begin
        re = (xr * yr - xi * yi) >>> FB;
        im = (xr * yi + xi * yr) >>> FB;
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
          re = 0;
          im = 0;
        end else begin
          den = yr * yr + yi * yi;
          re = ((xr * yr + xi * yi) <<< FB) / den;
          im = ((xi * yr - xr * yi) <<< FB) / den;
        end
      end
    endcase
    r.re = clamp_part(re, r.ovf);
    r.im = clamp_part(im, r.ovf);
    return r;
  endfunction

  // Count input transfers, predict, and check output transfers
  always @(posedge clk) begin
    cplx_res_t e;
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      n_in_xfer <= n_in_xfer + 1;
      if (cur_typed) cplx_expected_q.push_back(cur_res);
      else cplx_expected_q.push_back(cplx_compute(opcode_t'(opcode), a_real, a_imag,
                                                  b_real, b_imag));
    end
    if (!rst && out_valid && out_ready) begin
      if (cplx_expected_q.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, result_real, result_imag);
        failed = 1'b1;
      end else begin
        e = cplx_expected_q.pop_front();
        if (result_real !== e.re) begin
          $display("%0t: result_real exp %h act %h", $time, e.re, result_real);
          failed = 1'b1;
        end
        if (result_imag !== e.im) begin
          $display("%0t: result_imag exp %h act %h", $time, e.im, result_imag);
          failed = 1'b1;
        end
        if (divide_by_zero !== e.dz) begin
          $display("%0t: divide_by_zero exp %b act %b", $time, e.dz, divide_by_zero);
          failed = 1'b1;
        end
        if (overflow !== e.ovf) begin
          $display("%0t: overflow exp %b act %b", $time, e.ovf, overflow);
          failed = 1'b1;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_ready = no_idle || ($urandom_range(99) >= 15);
  end

  task automatic send_item(input vec_t v);
    int target;
    if (!no_idle && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    opcode = v.op;
    a_real = v.ar; a_imag = v.ai; b_real = v.br; b_imag = v.bi;
    cur_typed = v.typed;
    cur_res = v.res;
    in_valid = 1'b1;
    target = n_in_xfer + 1;
    do @(negedge clk); while (n_in_xfer < target);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(8 << FB)) - (4 << FB));
      2: return word_t'($signed($urandom_range(512)) - 256);
      3: return $urandom_range(1) ? WMAX : WMIN;
      4: return '0;
      default: return word_t'($signed($urandom_range(256 << FB)) - (128 << FB));
    endcase
  endfunction

  function automatic vec_t mk(input opcode_t op, input word_t ar, input word_t ai,
                              input word_t br, input word_t bi);
    vec_t v;
    v.op = op; v.ar = ar; v.ai = ai; v.br = br; v.bi = bi;
    v.typed = 1'b0;
    v.res = '{re: '0, im: '0, dz: 1'b0, ovf: 1'b0};
    return v;
  endfunction

  function automatic vec_t mk_typed(input opcode_t op, input word_t ar, input word_t ai,
                                    input word_t br, input word_t bi, input word_t re,
                                    input word_t im, input logic dz, input logic ovf);
    vec_t v;
    v = mk(op, ar, ai, br, bi);
    v.typed = 1'b1;
    v.res = '{re: re, im: im, dz: dz, ovf: ovf};
    return v;
  endfunction

  initial begin
    vec_t table_q[$];
    vec_t v;
    table_q.push_back(mk_typed(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0));
    table_q.push_back(mk_typed(OP_ADD, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0, 1));
    table_q.push_back(mk_typed(OP_SUB, WMIN, WMAX, WMAX, WMIN, WMIN, WMAX, 0, 1));
    table_q.push_back(mk_typed(OP_SUB, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 0));
    table_q.push_back(mk_typed(OP_ADD, WMAX, -1, 0, 1, WMAX, 0, 0, 0));
    table_q.push_back(mk_typed(OP_MUL, ONE, 0, ONE, 0, ONE, 0, 0, 0));
    table_q.push_back(mk_typed(OP_MUL, 0, ONE, 0, ONE, -ONE, 0, 0, 0));
    table_q.push_back(mk_typed(OP_MUL, WMAX, WMAX, WMAX, WMAX, 0, WMAX, 0, 1));
    table_q.push_back(mk(OP_MUL, WMIN, WMIN, WMIN, WMIN));
    table_q.push_back(mk(OP_MUL, -1, 0, 1, 0));
    table_q.push_back(mk_typed(OP_DIV, ONE, ONE, 0, 0, 0, 0, 1, 0));
    table_q.push_back(mk_typed(OP_DIV, WMAX, WMIN, 0, 0, 0, 0, 1, 0));
    table_q.push_back(mk_typed(OP_DIV, ONE, 0, ONE, 0, ONE, 0, 0, 0));
    table_q.push_back(mk(OP_DIV, WMAX, WMAX, 1, 0));
    table_q.push_back(mk(OP_DIV, WMIN, WMIN, 0, 1));
    table_q.push_back(mk(OP_DIV, -ONE, 3, 3 << FB, 0));
    table_q.push_back(mk(OP_DIV, ONE, 0, WMIN, WMIN));
    table_q.push_back(mk(OP_DIV, 7 << FB, -5 << FB, 2 << FB, 3 << FB));
    table_q.push_back(mk(OP_SUB, 5 << FB, 0, 7 << FB, 0));
    table_q.push_back(mk(OP_MUL, -3 << FB, 2 << FB, 1 << (FB - 1), -1));

    repeat (7) @(negedge clk);
    rst = 1'b0;

    foreach (table_q[i]) send_item(table_q[i]);

    for (int n = 0; n < N_RAND; n++) begin
      no_idle = (n >= 400 && n < 600);
      v = mk(opcode_t'($urandom_range(3)), rand_word(), rand_word(), rand_word(), rand_word());
      // Exercise the zero-divisor path now and then
      if (v.op == OP_DIV && $urandom_range(9) == 0) begin
        v.br = '0;
        v.bi = '0;
      end
      send_item(v);
    end
    no_idle = 1'b0;
    in_valid = 1'b0;

    wait (cplx_expected_q.size() == 0);
    repeat (3 * DW) @(negedge clk);
    if (!failed && cplx_expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/cna_pkg.sv
hdl/cna_div_stage.sv
hdl/complex_number_alu_top.sv
tb/sv/tb_top.sv
